// File: rtl/rchp_pkg.sv
// Types, constants and decode functions shared by the RTMP chunk header parser.
package rchp_pkg;

    localparam logic       REQ_HEADER   = 1'b0;
    localparam logic       REQ_COMPLETE = 1'b1;

    localparam logic       KIND_HEADER  = 1'b0;
    localparam logic       KIND_FLV     = 1'b1;

    localparam logic [1:0] FMT_0 = 2'd0;
    localparam logic [1:0] FMT_1 = 2'd1;
    localparam logic [1:0] FMT_2 = 2'd2;
    localparam logic [1:0] FMT_3 = 2'd3;

    localparam logic [3:0] POS_IDLE  = 4'd0;
    localparam logic [3:0] POS_BASIC = 4'd1;
    localparam logic [3:0] POS_TS0   = 4'd1;
    localparam logic [3:0] POS_TS1   = 4'd2;
    localparam logic [3:0] POS_TS2   = 4'd3;
    localparam logic [3:0] POS_LEN0  = 4'd4;
    localparam logic [3:0] POS_LEN1  = 4'd5;
    localparam logic [3:0] POS_LEN2  = 4'd6;
    localparam logic [3:0] POS_TYPE  = 4'd7;
    localparam logic [3:0] POS_SID0  = 4'd8;
    localparam logic [3:0] POS_SID1  = 4'd9;
    localparam logic [3:0] POS_SID2  = 4'd10;
    localparam logic [3:0] POS_SID3  = 4'd11;

    localparam logic [7:0] TYPE_ABORT      = 8'd2;
    localparam logic [7:0] TYPE_ACK        = 8'd3;
    localparam logic [7:0] TYPE_USER_CTRL  = 8'd4;
    localparam logic [7:0] TYPE_AUDIO      = 8'd8;
    localparam logic [7:0] TYPE_VIDEO      = 8'd9;
    localparam logic [7:0] TYPE_DATA       = 8'd18;
    localparam logic [4:0] TYPE_OTHER      = 5'd0;

    typedef struct packed {
        logic        kind;
        logic [1:0]  fmt;
        logic [5:0]  csid;
        logic [3:0]  hlen;
        logic [23:0] ts;
        logic [23:0] len;
        logic [4:0]  mtype;
        logic [31:0] msid;
        logic [23:0] flv;
    } rchp_result_t;

    function automatic logic [3:0] header_total(input logic [1:0] fmt);
        logic [3:0] total;
        unique case (fmt)
            FMT_0:   total = 4'd12;
            FMT_1:   total = 4'd8;
            FMT_2:   total = 4'd4;
            default: total = 4'd1;
        endcase
        return total;
    endfunction

    function automatic logic [4:0] classify_type(input logic [7:0] b);
        logic [4:0] t;
        unique case (b) inside
            TYPE_ABORT, TYPE_ACK, TYPE_USER_CTRL, TYPE_AUDIO, TYPE_VIDEO, TYPE_DATA:
                t = b[4:0];
            default:
                t = TYPE_OTHER;
        endcase
        return t;
    endfunction

endpackage

// File: rtl/rchp_parse.sv
// Header state registers, per-byte field update and result formation.
module rchp_parse
    import rchp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         accept,
    input  logic         req_type,
    input  logic [7:0]   data_byte,
    input  logic         first_byte,
    output logic         res_valid,
    output rchp_result_t res
);

    logic [3:0]  pos_reg, pos_next;
    logic [1:0]  fmt_reg, fmt_next;
    logic [5:0]  csid_reg, csid_next;
    logic [23:0] ts_reg, ts_next;
    logic [23:0] len_reg, len_next;
    logic [4:0]  mtype_reg, mtype_next;
    logic [31:0] msid_reg, msid_next;
    logic [31:0] acc_reg, acc_next;
    logic        hdr_step;
    logic        kind;

    always_comb
    begin
        pos_next   = pos_reg;
        fmt_next   = fmt_reg;
        csid_next  = csid_reg;
        ts_next    = ts_reg;
        len_next   = len_reg;
        mtype_next = mtype_reg;
        msid_next  = msid_reg;
        acc_next   = acc_reg;
        hdr_step   = 1'b0;
        res_valid  = 1'b0;
        kind       = KIND_HEADER;
        if (accept)
        begin
            if (req_type == REQ_COMPLETE)
            begin
                acc_next  = acc_reg + {8'd0, ts_reg};
                res_valid = 1'b1;
                kind      = KIND_FLV;
            end
            else if (first_byte)
            begin
                fmt_next  = data_byte[7:6];
                csid_next = data_byte[5:0];
                pos_next  = POS_BASIC;
                hdr_step  = 1'b1;
            end
            else if (pos_reg != POS_IDLE && pos_reg < header_total(fmt_reg))
            begin
                case (pos_reg)
                    POS_TS0:  ts_next[23:16]   = data_byte;
                    POS_TS1:  ts_next[15:8]    = data_byte;
                    POS_TS2:  ts_next[7:0]     = data_byte;
                    POS_LEN0: len_next[23:16]  = data_byte;
                    POS_LEN1: len_next[15:8]   = data_byte;
                    POS_LEN2: len_next[7:0]    = data_byte;
                    POS_TYPE: mtype_next       = classify_type(data_byte);
                    POS_SID0: msid_next[7:0]   = data_byte;
                    POS_SID1: msid_next[15:8]  = data_byte;
                    POS_SID2: msid_next[23:16] = data_byte;
                    POS_SID3: msid_next[31:24] = data_byte;
                    default:  ;
                endcase
                pos_next = pos_reg + 4'd1;
                hdr_step = 1'b1;
            end
            // close the header once its last byte is in
            if (hdr_step && pos_next >= header_total(fmt_next))
            begin
                pos_next  = POS_IDLE;
                res_valid = 1'b1;
            end
        end
    end

    always_comb
    begin
        res.kind  = kind;
        res.fmt   = fmt_next;
        res.csid  = csid_next;
        res.hlen  = header_total(fmt_next);
        res.ts    = ts_next;
        res.len   = len_next;
        res.mtype = mtype_next;
        res.msid  = msid_next;
        res.flv   = (kind == KIND_FLV) ? acc_next[23:0] : 24'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= POS_IDLE;
            fmt_reg   <= FMT_0;
            csid_reg  <= '0;
            ts_reg    <= '0;
            len_reg   <= '0;
            mtype_reg <= TYPE_OTHER;
            msid_reg  <= '0;
            acc_reg   <= '0;
        end
        else
        begin
            pos_reg   <= pos_next;
            fmt_reg   <= fmt_next;
            csid_reg  <= csid_next;
            ts_reg    <= ts_next;
            len_reg   <= len_next;
            mtype_reg <= mtype_next;
            msid_reg  <= msid_next;
            acc_reg   <= acc_next;
        end
    end

endmodule

// File: rtl/rchp_out_buf.sv
// Result register with skid stage between parser and result channel.
module rchp_out_buf
    import rchp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  rchp_result_t push_data,
    output logic         full,
    output logic         out_valid,
    input  logic         out_stall,
    output rchp_result_t out_data
);

    logic         out_valid_reg, out_valid_next;
    logic         skid_valid_reg, skid_valid_next;
    rchp_result_t out_data_reg, out_data_next;
    rchp_result_t skid_data_reg, skid_data_next;
    logic         pop;

    assign pop = out_valid_reg && !out_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_data_next  = push_data;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_data_next  = push_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// File: rtl/rtmp_chunk_header_parser.sv
// RTMP chunk header parser: one header byte or message-complete word per cycle,
// decoded header and FLV tag fields out. Each accepted word is handled in the
// cycle it is taken: the stored fields update at once and any result is
// registered in the result buffer, both for the word that closes a header
// (format 3 closes on its start byte) and for a message-complete word.
// One word is taken per cycle while item_stall is low, the rate set by the single
// field-update path; a two-entry result buffer keeps input flowing while one
// result waits, and item_stall rises only when both entries are held.
module rtmp_chunk_header_parser
    import rchp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         item_valid,
    output logic         item_stall,
    input  logic         req_type,
    input  logic [7:0]   data_byte,
    input  logic         first_byte,
    output logic         result_valid,
    input  logic         result_stall,
    output logic         result_kind,
    output logic [1:0]   format_code,
    output logic [5:0]   chunk_stream_id,
    output logic [3:0]   header_length,
    output logic [23:0]  timestamp_field,
    output logic [23:0]  message_length,
    output logic [4:0]   message_type,
    output logic [31:0]  message_stream_id,
    output logic [23:0]  flv_timestamp
);

    logic         accept;
    logic         res_valid;
    rchp_result_t res;
    rchp_result_t out_data;
    logic         full;

    assign item_stall = full;
    assign accept     = item_valid && !full;

    rchp_parse u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .req_type   (req_type),
        .data_byte  (data_byte),
        .first_byte (first_byte),
        .res_valid  (res_valid),
        .res        (res)
    );

    rchp_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .full      (full),
        .out_valid (result_valid),
        .out_stall (result_stall),
        .out_data  (out_data)
    );

    assign result_kind       = out_data.kind;
    assign format_code       = out_data.fmt;
    assign chunk_stream_id   = out_data.csid;
    assign header_length     = out_data.hlen;
    assign timestamp_field   = out_data.ts;
    assign message_length    = out_data.len;
    assign message_type      = out_data.mtype;
    assign message_stream_id = out_data.msid;
    assign flv_timestamp     = out_data.flv;

    a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> result_valid)
        else $error("input stalled with no result pending");

    a_header_flv_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_kind == KIND_HEADER) |-> flv_timestamp == 24'd0)
        else $error("header result carries a tag timestamp");

    a_fmt3_length: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && format_code == FMT_3) |-> header_length == 4'd1)
        else $error("format 3 header length wrong");

endmodule

// File: sim/rtmp_chunk_header_parser_tb.sv
// Testbench for the RTMP chunk header parser: random chunk byte streams checked field by field.
`timescale 1ns / 100ps

module rtmp_chunk_header_parser_tb
    import rchp_pkg::*;
();

    localparam int STUCK_LIMIT     = 4000;
    localparam int HOLD_CYCLES     = 300;
    localparam int WORDS_PER_STAGE = 545;

    typedef struct packed {
        logic       req;
        logic [7:0] b;
        logic       first;
    } chunk_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        item_valid = 1'b0;
    logic        item_stall;
    logic        req_type = REQ_HEADER;
    logic [7:0]  data_byte = 8'h00;
    logic        first_byte = 1'b0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic        result_kind;
    logic [1:0]  format_code;
    logic [5:0]  chunk_stream_id;
    logic [3:0]  header_length;
    logic [23:0] timestamp_field;
    logic [23:0] message_length;
    logic [4:0]  message_type;
    logic [31:0] message_stream_id;
    logic [23:0] flv_timestamp;

    chunk_word_t  words_to_send[$];
    chunk_word_t  next_word;
    rchp_result_t decoded_expected[$];

    int   send_idle_pct = 9;
    int   recv_idle_pct = 70;
    logic hold_go = 1'b0;
    logic hold_done = 1'b0;
    int   hold_left = 0;
    int   stuck_cycles = 0;
    int   mismatches = 0;
    int   stage;

    logic [3:0]  pos = POS_IDLE;
    logic [1:0]  cur_fmt = FMT_0;
    logic [5:0]  cur_csid = 6'd0;
    logic [23:0] st_ts = 24'd0;
    logic [23:0] st_len = 24'd0;
    logic [4:0]  st_type = TYPE_OTHER;
    logic [31:0] st_msid = 32'd0;
    logic [31:0] ts_acc = 32'd0;

    rtmp_chunk_header_parser uut (
        .clk               (clk),
        .rst_n             (rst_n),
        .item_valid        (item_valid),
        .item_stall        (item_stall),
        .req_type          (req_type),
        .data_byte         (data_byte),
        .first_byte        (first_byte),
        .result_valid      (result_valid),
        .result_stall      (result_stall),
        .result_kind       (result_kind),
        .format_code       (format_code),
        .chunk_stream_id   (chunk_stream_id),
        .header_length     (header_length),
        .timestamp_field   (timestamp_field),
        .message_length    (message_length),
        .message_type      (message_type),
        .message_stream_id (message_stream_id),
        .flv_timestamp     (flv_timestamp)
    );

    function automatic logic [3:0] header_bytes(input logic [1:0] fmt);
        logic [3:0] total;
        case (fmt)
            FMT_0:   total = 4'd12;
            FMT_1:   total = 4'd8;
            FMT_2:   total = 4'd4;
            default: total = 4'd1;
        endcase
        return total;
    endfunction

    function automatic logic [4:0] kept_type(input logic [7:0] b);
        logic [4:0] t;
        t = TYPE_OTHER;
        if (b == TYPE_ABORT || b == TYPE_ACK || b == TYPE_USER_CTRL || b == TYPE_AUDIO
            || b == TYPE_VIDEO || b == TYPE_DATA)
            t = b[4:0];
        return t;
    endfunction

    function automatic rchp_result_t tag_fields(input logic kind, input logic [23:0] flv);
        rchp_result_t r;
        r.kind  = kind;
        r.fmt   = cur_fmt;
        r.csid  = cur_csid;
        r.hlen  = header_bytes(cur_fmt);
        r.ts    = st_ts;
        r.len   = st_len;
        r.mtype = st_type;
        r.msid  = st_msid;
        r.flv   = flv;
        return r;
    endfunction

    task automatic parse_word(input chunk_word_t w);
        int   sh;
        logic taken;
        taken = 1'b1;
        if (w.req == REQ_COMPLETE)
        begin
            ts_acc = ts_acc + {8'h00, st_ts};
            decoded_expected.push_back(tag_fields(KIND_FLV, ts_acc[23:0]));
        end
        else
        begin
            if (w.first)
            begin
                cur_fmt  = w.b[7:6];
                cur_csid = w.b[5:0];
                pos      = POS_BASIC;
            end
            else if (pos == POS_IDLE || pos >= header_bytes(cur_fmt))
            begin
                taken = 1'b0;
            end
            else
            begin
                if (pos <= POS_TS2)
                begin
                    sh = 8 * (int'(POS_TS2) - int'(pos));
                    st_ts[sh +: 8] = w.b;
                end
                else if (pos <= POS_LEN2)
                begin
                    sh = 8 * (int'(POS_LEN2) - int'(pos));
                    st_len[sh +: 8] = w.b;
                end
                else if (pos == POS_TYPE)
                begin
                    st_type = kept_type(w.b);
                end
                else
                begin
                    sh = 8 * (int'(pos) - int'(POS_SID0));
                    st_msid[sh +: 8] = w.b;
                end
                pos = pos + 4'd1;
            end
            if (taken && pos >= header_bytes(cur_fmt))
            begin
                pos = POS_IDLE;
                decoded_expected.push_back(tag_fields(KIND_HEADER, 24'h000000));
            end
        end
    endtask

    task automatic check_tag();
        rchp_result_t want;
        rchp_result_t got;
        got.kind  = result_kind;
        got.fmt   = format_code;
        got.csid  = chunk_stream_id;
        got.hlen  = header_length;
        got.ts    = timestamp_field;
        got.len   = message_length;
        got.mtype = message_type;
        got.msid  = message_stream_id;
        got.flv   = flv_timestamp;
        if (decoded_expected.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: kind=%0d fmt=%0d csid=%0d",
                         got.kind, got.fmt, got.csid);
        end
        else
        begin
            want = decoded_expected.pop_front();
            if (got.kind !== want.kind || got.fmt !== want.fmt || got.csid !== want.csid
                || got.hlen !== want.hlen || got.ts !== want.ts || got.len !== want.len
                || got.mtype !== want.mtype || got.msid !== want.msid
                || got.flv !== want.flv)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display({"expected kind=%0d fmt=%0d csid=%0d hlen=%0d ts=%h len=%h",
                              " type=%0d msid=%h flv=%h"},
                             want.kind, want.fmt, want.csid, want.hlen, want.ts, want.len,
                             want.mtype, want.msid, want.flv);
                    $display({"actual   kind=%0d fmt=%0d csid=%0d hlen=%0d ts=%h len=%h",
                              " type=%0d msid=%h flv=%h"},
                             got.kind, got.fmt, got.csid, got.hlen, got.ts, got.len,
                             got.mtype, got.msid, got.flv);
                end
            end
        end
    endtask

    task automatic add_word(input logic req, input logic [7:0] b, input logic first);
        chunk_word_t w;
        w.req   = req;
        w.b     = b;
        w.first = first;
        words_to_send.push_back(w);
    endtask

    task automatic add_header(input logic [1:0] fmt, input int n_body, input bit interleave);
        int         i;
        logic [7:0] b;
        add_word(REQ_HEADER, {fmt, 6'($urandom_range(63))}, 1'b1);
        for (i = 1; i <= n_body; i++)
        begin
            if (interleave && $urandom_range(9) == 0)
                add_word(REQ_COMPLETE, 8'($urandom_range(255)), 1'($urandom_range(1)));
            b = 8'($urandom_range(255));
            case ($urandom_range(9))
                0:       b = 8'h00;
                1:       b = 8'hFF;
                default: ;
            endcase
            if (i == int'(POS_TYPE) && $urandom_range(1) == 1)
            begin
                case ($urandom_range(5))
                    0:       b = TYPE_ABORT;
                    1:       b = TYPE_ACK;
                    2:       b = TYPE_USER_CTRL;
                    3:       b = TYPE_AUDIO;
                    4:       b = TYPE_VIDEO;
                    default: b = TYPE_DATA;
                endcase
            end
            add_word(REQ_HEADER, b, 1'b0);
        end
    endtask

    task automatic make_random(input int target);
        int         made;
        int         before_n;
        int         pick;
        bit         stray;
        logic [1:0] fmt;
        made = 0;
        while (made < target)
        begin
            before_n = words_to_send.size();
            pick     = int'($urandom_range(99));
            fmt      = 2'($urandom_range(3));
            stray    = 1'b0;
            if (pick < 60)
            begin
                add_header(fmt, int'(header_bytes(fmt)) - 1, 1'b1);
            end
            else if (pick < 75)
            begin
                add_word(REQ_COMPLETE, 8'($urandom_range(255)), 1'($urandom_range(1)));
            end
            else if (pick < 87)
            begin
                add_header(fmt, int'($urandom_range(int'(header_bytes(fmt)) - 1)), 1'b0);
            end
            else if (pick < 95)
            begin
                stray = 1'b1;
                repeat ($urandom_range(1, 3))
                    add_word(REQ_HEADER, 8'($urandom_range(255)), 1'b0);
            end
            else
            begin
                add_word(REQ_HEADER, 8'($urandom_range(255)), 1'b1);
            end
            if (!stray)
                made += words_to_send.size() - before_n;
        end
    endtask

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            req_type   <= REQ_HEADER;
            data_byte  <= 8'h00;
            first_byte <= 1'b0;
        end
        else if (!item_valid || !item_stall)
        begin
            if (words_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                next_word = words_to_send.pop_front();
                item_valid <= 1'b1;
                req_type   <= next_word.req;
                data_byte  <= next_word.b;
                first_byte <= next_word.first;
            end
            else
            begin
                item_valid <= 1'b0;
            end
        end
    end

    // hold off once for a long stretch so the input side backs up
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            hold_left    <= 0;
            hold_done    <= 1'b0;
        end
        else if (hold_go && !hold_done)
        begin
            hold_done    <= 1'b1;
            hold_left    <= HOLD_CYCLES;
            result_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left    <= hold_left - 1;
            result_stall <= 1'b1;
        end
        else
        begin
            result_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && !item_stall)
                parse_word('{req_type, data_byte, first_byte});
            if (result_valid && !result_stall)
                check_tag();
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stuck_cycles <= 0;
        end
        else if ((item_valid && !item_stall) || (result_valid && !result_stall))
        begin
            stuck_cycles <= 0;
        end
        else if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
        begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        add_word(REQ_COMPLETE, 8'hFF, 1'b1);
        add_word(REQ_HEADER, {FMT_0, 6'd0}, 1'b1);
        repeat (6) add_word(REQ_HEADER, 8'hFF, 1'b0);
        add_word(REQ_HEADER, 8'h07, 1'b0);
        repeat (4) add_word(REQ_HEADER, 8'hFF, 1'b0);
        add_word(REQ_COMPLETE, 8'h00, 1'b0);
        add_word(REQ_HEADER, {FMT_3, 6'd63}, 1'b1);
        add_word(REQ_HEADER, 8'hA5, 1'b0);
        add_word(REQ_HEADER, {FMT_2, 6'd42}, 1'b1);
        add_word(REQ_HEADER, 8'h00, 1'b0);
        add_word(REQ_COMPLETE, 8'h5A, 1'b0);
        add_word(REQ_HEADER, 8'h00, 1'b0);
        add_word(REQ_HEADER, 8'h01, 1'b0);
        add_word(REQ_HEADER, {FMT_1, 6'd1}, 1'b1);
        add_word(REQ_HEADER, 8'h12, 1'b0);
        add_word(REQ_HEADER, {FMT_3, 6'd0}, 1'b1);
        add_word(REQ_COMPLETE, 8'h00, 1'b0);

        for (stage = 0; stage < 3; stage++)
        begin
            send_idle_pct = (stage == 0) ? 9 : (stage == 1) ? 70 : 0;
            recv_idle_pct = (stage == 0) ? 70 : (stage == 1) ? 9 : 0;
            make_random(WORDS_PER_STAGE);
            if (stage == 2)
                hold_go = 1'b1;
            while (words_to_send.size() != 0 || item_valid || decoded_expected.size() != 0)
                @(negedge clk);
        end

        repeat (20) @(negedge clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
